@@ hdl/fifo_queue_with_head_sum_and_mean_defines.svh @@
// Assertion macros used by the RTL in fifoq_back.
// Each check is sampled on the rising edge of clk and is off while arst_n is low.
`ifndef FIFO_QUEUE_WITH_HEAD_SUM_AND_MEAN_DEFINES_SVH
`define FIFO_QUEUE_WITH_HEAD_SUM_AND_MEAN_DEFINES_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge.
`define FQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`else

`define FQ_ASSERT_ALWAYS(lbl, cond, msg)
`define FQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hdl/fifoq_pkg.sv @@
package fifoq_pkg;

	// Queue geometry; DEPTH must be a power of two so that pointers wrap naturally
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Result widths
	localparam int SUM_W     = 36;
	localparam int MEAN_W    = 48;
	localparam int FRAC_BITS = 16;
	localparam int DIVD_W    = SUM_W + FRAC_BITS;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_SUM  = 2'd2,
		OP_MEAN = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// Command handed from the front end to the execution unit
	typedef struct packed {
		op_t                   op;
		logic [DATA_WIDTH-1:0] value;
		logic [CNT_W-1:0]      count;
	} cmd_t;

	// Result of one command
	typedef struct packed {
		status_t               status;
		logic [DATA_WIDTH-1:0] front;
		logic [CNT_W-1:0]      occupancy;
		logic [SUM_W-1:0]      head_sum;
		logic [MEAN_W-1:0]     mean;
	} res_t;

endpackage

@@ hdl/fifoq_front.sv @@
module fifoq_front import fifoq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // item_value [31:0], head_count [36:32], zero pad
	input  logic [1:0]  s_tuser,   // op [1:0]
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_pop
);

	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	cmd_t                cq_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] fill_q;
	logic                push;
	cmd_t                decoded;

	assign s_tready  = (fill_q != CQ_CNT_W'(CQ_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign push      = s_tvalid && s_tready;
	assign cmd       = cq_q[rd_ptr_q];

	// Classify the transaction into a command
	always_comb begin
		decoded.op    = op_t'(s_tuser);
		decoded.value = s_tdata[DATA_WIDTH-1:0];
		decoded.count = s_tdata[DATA_WIDTH +: CNT_W];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cq_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, cmd_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ hdl/fifoq_div.sv @@
module fifoq_div import fifoq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              done,
	output logic [DIVD_W-1:0] quotient
);

	// Restoring division, several quotient bits per cycle
	localparam int STEPS  = 4;
	localparam int ITERS  = DIVD_W / STEPS;
	localparam int ITER_W = $clog2(ITERS + 1);

	logic [DIVD_W-1:0] quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [ITER_W-1:0] iter_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVD_W-1:0] quo_nx;
	logic [CNT_W-1:0]  rem_nx;

	always_comb begin
		logic [CNT_W:0] trial;
		quo_nx = quo_q;
		rem_nx = rem_q;
		for (int i = 0; i < STEPS; i++) begin
			trial = {rem_nx, quo_nx[DIVD_W-1]};
			if (trial >= {1'b0, div_q}) begin
				rem_nx = CNT_W'(trial - {1'b0, div_q});
				quo_nx = {quo_nx[DIVD_W-2:0], 1'b1};
			end else begin
				rem_nx = trial[CNT_W-1:0];
				quo_nx = {quo_nx[DIVD_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= !start && busy_q && (iter_q == ITER_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(ITERS);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hdl/fifoq_back.sv @@
`include "fifo_queue_with_head_sum_and_mean_defines.svh"

module fifoq_back import fifoq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic res_valid,
	output res_t res,
	input  logic res_ready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_POP,
		S_SUM,
		S_DIV_START,
		S_DIV_WAIT,
		S_FRONT,
		S_RESULT
	} state_t;

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [PTR_W-1:0]      head_q;
	logic [PTR_W-1:0]      tail_q;
	logic [CNT_W-1:0]      count_q;
	logic [SUM_W-1:0]      total_q;
	logic [PTR_W-1:0]      walk_ptr_q;
	logic [CNT_W-1:0]      left_q;
	logic                  rd_vld_q;
	logic [SUM_W-1:0]      acc_q;
	logic [MEAN_W-1:0]     mean_q;
	status_t               status_q;
	logic                  res_valid_q;
	res_t                  res_q;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [PTR_W-1:0]      rd_addr;
	logic                  mem_we;
	logic [SUM_W-1:0]      rd_ext;
	logic [SUM_W-1:0]      val_ext;
	logic [SUM_W-1:0]      total_mag;
	logic                  div_start;
	logic                  div_done;
	logic [DIVD_W-1:0]     div_quo;
	logic [MEAN_W-1:0]     quo_trunc;
	logic [CNT_W-1:0]      sum_len;

	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign mem_we    = (state_q == S_PUSH) && (count_q != CNT_W'(DEPTH));
	assign rd_addr   = ((state_q == S_SUM) && (left_q != '0)) ? walk_ptr_q : head_q;
	assign rd_ext    = {{(SUM_W-DATA_WIDTH){rd_data_q[DATA_WIDTH-1]}}, rd_data_q};
	assign val_ext   = {{(SUM_W-DATA_WIDTH){cmd_q.value[DATA_WIDTH-1]}}, cmd_q.value};
	assign total_mag = total_q[SUM_W-1] ? (~total_q + 1'b1) : total_q;
	assign div_start = (state_q == S_DIV_START);
	assign quo_trunc = div_quo[MEAN_W-1:0];
	assign sum_len   = (cmd.count < count_q) ? cmd.count : count_q;

	// Entry store: one write port at the tail, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_q] <= cmd_q.value;
		end
		rd_data_q <= mem[rd_addr];
	end

	fifoq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({total_mag, {FRAC_BITS{1'b0}}}),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			total_q     <= '0;
			left_q      <= '0;
			rd_vld_q    <= 1'b0;
			res_valid_q <= 1'b0;
			cmd_q       <= '0;
			walk_ptr_q  <= '0;
			acc_q       <= '0;
			mean_q      <= '0;
			status_q    <= STAT_OK;
			res_q       <= '0;
		end else begin
			if (res_ready && (state_q != S_RESULT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q      <= cmd;
						status_q   <= ((cmd.op == OP_MEAN) && (count_q == '0)) ?
							STAT_EMPTY : STAT_OK;
						acc_q      <= '0;
						mean_q     <= '0;
						walk_ptr_q <= head_q;
						left_q     <= sum_len;
						rd_vld_q   <= 1'b0;
						case (cmd.op)
							OP_PUSH: state_q <= S_PUSH;
							OP_POP:  state_q <= S_POP;
							OP_SUM:  state_q <= S_SUM;
							OP_MEAN: state_q <= (count_q == '0) ? S_FRONT : S_DIV_START;
							default: state_q <= S_FRONT;
						endcase
					end
				end
				S_PUSH: begin
					if (count_q == CNT_W'(DEPTH)) begin
						status_q <= STAT_FULL;
					end else begin
						tail_q  <= tail_q + 1'b1;
						count_q <= count_q + 1'b1;
						total_q <= total_q + val_ext;
					end
					state_q <= S_FRONT;
				end
				S_POP: begin
					// rd_data_q holds the head entry, read while idle
					if (count_q == '0) begin
						status_q <= STAT_EMPTY;
					end else begin
						total_q <= total_q - rd_ext;
						head_q  <= head_q + 1'b1;
						count_q <= count_q - 1'b1;
					end
					state_q <= S_FRONT;
				end
				S_SUM: begin
					rd_vld_q <= (left_q != '0);
					if (left_q != '0) begin
						walk_ptr_q <= walk_ptr_q + 1'b1;
						left_q     <= left_q - 1'b1;
					end
					if (rd_vld_q) begin
						acc_q <= acc_q + rd_ext;
					end
					if ((left_q == '0) && !rd_vld_q) begin
						state_q <= S_FRONT;
					end
				end
				S_DIV_START: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						mean_q  <= total_q[SUM_W-1] ? (~quo_trunc + 1'b1) : quo_trunc;
						state_q <= S_FRONT;
					end
				end
				S_FRONT: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q     <= 1'b1;
						res_q.status    <= status_q;
						res_q.front     <= (count_q != '0) ? rd_data_q : '0;
						res_q.occupancy <= count_q;
						res_q.head_sum  <= acc_q;
						res_q.mean      <= mean_q;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`FQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "occupancy above depth")
	`FQ_ASSERT_ALWAYS(a_ptr_track, tail_q == PTR_W'(head_q + count_q[PTR_W-1:0]), "pointers out of step with occupancy")
	`FQ_ASSERT_ALWAYS(a_empty_total, (count_q != '0) || (total_q == '0), "running total non-zero on empty queue")
	`FQ_ASSERT_ALWAYS(a_div_done_wait, !div_done || (state_q == S_DIV_WAIT), "divider finished outside its wait")
	`FQ_ASSERT_NEXT(a_take_cmd, cmd_pop, state_q != S_IDLE, "command taken but control stayed idle")

endmodule

@@ hdl/fifo_queue_with_head_sum_and_mean.sv @@
// Channel   Dir  Bits  Contents (lowest bit up)
// s_        in   40    tdata: item_value[31:0], head_count[36:32]; tuser: op[1:0]
// m_        out  128   tdata: front_value[31:0], occupancy[36:32], head_sum[72:37],
//                      mean_fixed[120:73]; tuser: status[1:0]
//
// Sequence: push and pop pass through S_PUSH or S_POP, S_FRONT and S_RESULT; a
// head sum of k entries reads one entry per cycle from the single read port, and
// a mean waits on the divider, which retires four quotient bits per cycle.
// Reset: arst_n clears the queue pointers, occupancy and running total; the entry
// store needs no clearing since only occupied entries are read.
// Stalls: a two-deep command queue lets the input side run ahead of execution;
// the output register holds a finished result while the next command starts.
module fifo_queue_with_head_sum_and_mean import fifoq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // item_value [31:0], head_count [36:32], zero pad
	input  logic [1:0]   s_tuser,   // op [1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // front_value [31:0], occupancy [36:32],
	                                // head_sum [72:37], mean_fixed [120:73], zero pad
	output logic [1:0]   m_tuser    // status [1:0]
);

	localparam int M_PAD = 128 - (DATA_WIDTH + CNT_W + SUM_W + MEAN_W);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	res_t res;

	// Front end: take each transaction and queue it as a decoded command
	fifoq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Back end: hold the queue state, execute one command at a time
	fifoq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (m_tvalid),
		.res       (res),
		.res_ready (m_tready)
	);

	// Pack the registered result onto the master side
	assign m_tdata = {{M_PAD{1'b0}}, res.mean, res.head_sum, res.occupancy, res.front};
	assign m_tuser = res.status;

endmodule
